@@ design/pixel_to_normalized_undistort_defines.svh @@
// ----------------------------------------------------------------------------
// pixel_to_normalized_undistort_defines
// assertion macros shared by the pixel normalization block
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_NORMALIZED_UNDISTORT_DEFINES_SVH
`define PIXEL_TO_NORMALIZED_UNDISTORT_DEFINES_SVH

// same-cycle implication
`define PNU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PNU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pnu_pkg.sv @@
// ----------------------------------------------------------------------------
// pnu_pkg
// types, register codes and fixed-point helpers for the normalization block
// ----------------------------------------------------------------------------
package pnu_pkg;

  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned ADDR_W    = 6;

  typedef enum logic [1:0] {
    MODE_PINHOLE = 2'd0,
    MODE_RADIAL  = 2'd1,
    MODE_RADTAN  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_FOCAL = 3'd1,
    REG_PP    = 3'd2,
    REG_K12   = 3'd3,
    REG_K34   = 3'd4,
    REG_TAN   = 3'd5
  } reg_idx_e;

  localparam logic [63:0]        FOCAL_RST = 64'h0001_0000_0001_0000;
  localparam logic signed [31:0] S32_MAX   = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] Q24_ONE   = 32'sh0100_0000;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] k4;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic               fault;
  } res_t;

  function automatic logic signed [39:0] ext40(input logic signed [31:0] a);
    logic signed [39:0] r;
    r = a;
    return r;
  endfunction

  function automatic sat_t sat40(input logic signed [39:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[31:0];
    if (v > ext40(S32_MAX)) begin
      r.ovf = 1'b1;
      r.val = S32_MAX;
    end else if (v < ext40(S32_MIN)) begin
      r.ovf = 1'b1;
      r.val = S32_MIN;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] ae;
    logic signed [63:0] be;
    ae = a;
    be = b;
    return ae * be;
  endfunction

  // scale a Q8.24 product back, truncating toward zero
  function automatic sat_t qfin(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd16777215 : 64'sd0);
    return sat40($signed(t[63:24]));
  endfunction

endpackage

@@ design/pnu_pix_if.sv @@
// ----------------------------------------------------------------------------
// pnu_pix_if
// input channel: one pixel point per beat
// ----------------------------------------------------------------------------
interface pnu_pix_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pixel_x;
  logic signed [31:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ design/pnu_norm_if.sv @@
// ----------------------------------------------------------------------------
// pnu_norm_if
// output channel: one normalized point per beat
// ----------------------------------------------------------------------------
interface pnu_norm_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic               fault;

  modport source (output valid, output norm_x, output norm_y, output fault, input ready);
  modport sink   (input valid, input norm_x, input norm_y, input fault, output ready);
endinterface

@@ design/pnu_div.sv @@
// ----------------------------------------------------------------------------
// pnu_div
// two-lane pipelined Q24 divider, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
module pnu_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               flt_i,
  input  logic signed [32:0] num_i [2],
  input  logic signed [32:0] den_i [2],
  output logic               valid_o,
  output logic               flt_o,
  output logic signed [31:0] quo_o [2]
);

  logic        v_q   [0:pnu_pkg::DIV_STEPS];
  logic        f_q   [0:pnu_pkg::DIV_STEPS];
  logic [31:0] rem_q [2][0:pnu_pkg::DIV_STEPS];
  logic [31:0] nb_q  [2][0:pnu_pkg::DIV_STEPS];
  logic [31:0] quo_q [2][0:pnu_pkg::DIV_STEPS];
  logic [31:0] dm_q  [2][0:pnu_pkg::DIV_STEPS];
  logic        neg_q [2][0:pnu_pkg::DIV_STEPS];
  logic        big_q [2][0:pnu_pkg::DIV_STEPS];
  logic        nz_q  [2][0:pnu_pkg::DIV_STEPS];

  logic [32:0] nabs [2];
  logic [32:0] dabs [2];
  logic        big  [2];
  logic [32:0] tr   [2][pnu_pkg::DIV_STEPS];
  logic [32:0] df   [2][pnu_pkg::DIV_STEPS];
  logic        ge   [2][pnu_pkg::DIV_STEPS];
  logic signed [31:0] res [2];
  logic        ovf  [2];

  // operand preparation
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nabs[l] = num_i[l][32] ? (~num_i[l] + 33'd1) : num_i[l];
      dabs[l] = den_i[l][32] ? (~den_i[l] + 33'd1) : den_i[l];
      big[l]  = {7'd0, nabs[l][32:8]} >= dabs[l][31:0];
    end
  end

  // one restoring step per stage
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < pnu_pkg::DIV_STEPS; k++) begin
        tr[l][k] = {rem_q[l][k], nb_q[l][k][31]};
        df[l][k] = tr[l][k] - {1'b0, dm_q[l][k]};
        ge[l][k] = tr[l][k] >= {1'b0, dm_q[l][k]};
      end
    end
  end

  // sign and saturation
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ovf[l] = 1'b0;
      res[l] = quo_q[l][pnu_pkg::DIV_STEPS];
      if (big_q[l][pnu_pkg::DIV_STEPS]) begin
        ovf[l] = 1'b1;
        if (!nz_q[l][pnu_pkg::DIV_STEPS]) begin
          res[l] = '0;
        end else if (neg_q[l][pnu_pkg::DIV_STEPS]) begin
          res[l] = pnu_pkg::S32_MIN;
        end else begin
          res[l] = pnu_pkg::S32_MAX;
        end
      end else if (!neg_q[l][pnu_pkg::DIV_STEPS]) begin
        if (quo_q[l][pnu_pkg::DIV_STEPS][31]) begin
          ovf[l] = 1'b1;
          res[l] = pnu_pkg::S32_MAX;
        end
      end else begin
        if (quo_q[l][pnu_pkg::DIV_STEPS][31] && (|quo_q[l][pnu_pkg::DIV_STEPS][30:0])) begin
          ovf[l] = 1'b1;
          res[l] = pnu_pkg::S32_MIN;
        end else begin
          res[l] = ~quo_q[l][pnu_pkg::DIV_STEPS] + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= pnu_pkg::DIV_STEPS; k++) v_q[k] <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 0; k < pnu_pkg::DIV_STEPS; k++) v_q[k+1] <= v_q[k];
      valid_o <= v_q[pnu_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q[0] <= flt_i;
      for (int k = 0; k < pnu_pkg::DIV_STEPS; k++) f_q[k+1] <= f_q[k];
      flt_o <= f_q[pnu_pkg::DIV_STEPS] | ovf[0] | ovf[1];
      for (int l = 0; l < 2; l++) begin
        rem_q[l][0] <= {7'd0, nabs[l][32:8]};
        nb_q[l][0]  <= {nabs[l][7:0], 24'd0};
        quo_q[l][0] <= '0;
        dm_q[l][0]  <= dabs[l][31:0];
        neg_q[l][0] <= num_i[l][32] ^ den_i[l][32];
        big_q[l][0] <= big[l];
        nz_q[l][0]  <= |nabs[l];
        for (int k = 0; k < pnu_pkg::DIV_STEPS; k++) begin
          rem_q[l][k+1] <= ge[l][k] ? df[l][k][31:0] : tr[l][k][31:0];
          nb_q[l][k+1]  <= {nb_q[l][k][30:0], 1'b0};
          quo_q[l][k+1] <= {quo_q[l][k][30:0], ge[l][k]};
          dm_q[l][k+1]  <= dm_q[l][k];
          neg_q[l][k+1] <= neg_q[l][k];
          big_q[l][k+1] <= big_q[l][k];
          nz_q[l][k+1]  <= nz_q[l][k];
        end
        quo_o[l] <= res[l];
      end
    end
  end

endmodule

@@ design/pnu_poly.sv @@
// ----------------------------------------------------------------------------
// pnu_poly
// radial factor and tangential terms, eight register stages
// ----------------------------------------------------------------------------
module pnu_poly (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic               flt_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] y_i,
  input  logic [1:0]         mode_i,
  input  pnu_pkg::coef_t     coef_i,
  output logic               valid_o,
  output logic               flt_o,
  output logic signed [31:0] ux_o,
  output logic signed [31:0] uy_o,
  output logic signed [31:0] d_o
);

  logic [6:0] v_q;

  logic signed [63:0] s1_pxx_q, s1_pyy_q, s1_pxy_q;
  logic signed [31:0] s1_x_q, s1_y_q;
  logic               s1_f_q;

  logic signed [31:0] s2_xx_q, s2_yy_q, s2_xy_q, s2_r2_q, s2_x_q, s2_y_q;
  logic               s2_f_q, s2_fr_q, s2_ft_q;

  logic signed [63:0] s3_pr4_q, s3_pk1_q, s3_pp1xy_q, s3_pp2xy_q;
  logic signed [31:0] s3_a2x_q, s3_a2y_q, s3_r2_q, s3_x_q, s3_y_q;
  logic               s3_f_q, s3_fr_q, s3_ft_q;

  logic signed [63:0] s4_pa_q, s4_pb_q;
  logic signed [31:0] s4_r4_q, s4_m1_q, s4_t1_q, s4_t2_q, s4_r2_q, s4_x_q, s4_y_q;
  logic               s4_f_q, s4_fr_q, s4_ft_q;

  logic signed [63:0] s5_pr6_q, s5_pr8_q, s5_pk2_q;
  logic signed [31:0] s5_ta_q, s5_tb_q, s5_t1_q, s5_t2_q, s5_m1_q, s5_x_q, s5_y_q;
  logic               s5_f_q, s5_fr_q, s5_ft_q;

  logic signed [31:0] s6_r6_q, s6_r8_q, s6_m2_q, s6_tx_q, s6_ty_q, s6_m1_q;
  logic signed [31:0] s6_x_q, s6_y_q;
  logic               s6_f_q, s6_fr_q, s6_ft_q;

  logic signed [63:0] s7_pk3_q, s7_pk4_q;
  logic signed [31:0] s7_ux_q, s7_uy_q, s7_m1_q, s7_m2_q, s7_x_q, s7_y_q;
  logic               s7_f_q, s7_fr_q, s7_ft_q;

  pnu_pkg::sat_t xx_s, yy_s, xy_s, r2_s, a2x_s, a2y_s, r4_s, m1_s, t1_s, t2_s;
  pnu_pkg::sat_t ta_s, tb_s, r6_s, r8_s, m2_s, tx_s, ty_s, ux_s, uy_s, m3_s, m4_s, d_s;
  logic          rad, tan;

  always_comb begin
    xx_s  = pnu_pkg::qfin(s1_pxx_q);
    yy_s  = pnu_pkg::qfin(s1_pyy_q);
    xy_s  = pnu_pkg::qfin(s1_pxy_q);
    r2_s  = pnu_pkg::sat40(pnu_pkg::ext40(xx_s.val) + pnu_pkg::ext40(yy_s.val));
    a2x_s = pnu_pkg::sat40(pnu_pkg::ext40(s2_r2_q) + (pnu_pkg::ext40(s2_xx_q) <<< 1));
    a2y_s = pnu_pkg::sat40(pnu_pkg::ext40(s2_r2_q) + (pnu_pkg::ext40(s2_yy_q) <<< 1));
    r4_s  = pnu_pkg::qfin(s3_pr4_q);
    m1_s  = pnu_pkg::qfin(s3_pk1_q);
    t1_s  = pnu_pkg::qfin(s3_pp1xy_q);
    t2_s  = pnu_pkg::qfin(s3_pp2xy_q);
    ta_s  = pnu_pkg::qfin(s4_pa_q);
    tb_s  = pnu_pkg::qfin(s4_pb_q);
    r6_s  = pnu_pkg::qfin(s5_pr6_q);
    r8_s  = pnu_pkg::qfin(s5_pr8_q);
    m2_s  = pnu_pkg::qfin(s5_pk2_q);
    tx_s  = pnu_pkg::sat40((pnu_pkg::ext40(s5_t1_q) <<< 1) + pnu_pkg::ext40(s5_ta_q));
    ty_s  = pnu_pkg::sat40(pnu_pkg::ext40(s5_tb_q) + (pnu_pkg::ext40(s5_t2_q) <<< 1));
    ux_s  = pnu_pkg::sat40(pnu_pkg::ext40(s6_x_q) - pnu_pkg::ext40(s6_tx_q));
    uy_s  = pnu_pkg::sat40(pnu_pkg::ext40(s6_y_q) - pnu_pkg::ext40(s6_ty_q));
    m3_s  = pnu_pkg::qfin(s7_pk3_q);
    m4_s  = pnu_pkg::qfin(s7_pk4_q);
    d_s   = pnu_pkg::sat40(pnu_pkg::ext40(pnu_pkg::Q24_ONE) + pnu_pkg::ext40(s7_m1_q)
                           + pnu_pkg::ext40(s7_m2_q) + pnu_pkg::ext40(m3_s.val)
                           + pnu_pkg::ext40(m4_s.val));
    tan   = (mode_i == pnu_pkg::MODE_RADTAN);
    rad   = (mode_i == pnu_pkg::MODE_RADIAL) || tan;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[5:0], valid_i};
      valid_o <= v_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_pxx_q <= pnu_pkg::smul(x_i, x_i);
      s1_pyy_q <= pnu_pkg::smul(y_i, y_i);
      s1_pxy_q <= pnu_pkg::smul(x_i, y_i);
      s1_x_q   <= x_i;
      s1_y_q   <= y_i;
      s1_f_q   <= flt_i;

      s2_xx_q <= xx_s.val;
      s2_yy_q <= yy_s.val;
      s2_xy_q <= xy_s.val;
      s2_r2_q <= r2_s.val;
      s2_x_q  <= s1_x_q;
      s2_y_q  <= s1_y_q;
      s2_f_q  <= s1_f_q;
      s2_fr_q <= xx_s.ovf | yy_s.ovf | r2_s.ovf;
      s2_ft_q <= xy_s.ovf;

      s3_pr4_q   <= pnu_pkg::smul(s2_r2_q, s2_r2_q);
      s3_pk1_q   <= pnu_pkg::smul(coef_i.k1, s2_r2_q);
      s3_pp1xy_q <= pnu_pkg::smul(coef_i.p1, s2_xy_q);
      s3_pp2xy_q <= pnu_pkg::smul(coef_i.p2, s2_xy_q);
      s3_a2x_q   <= a2x_s.val;
      s3_a2y_q   <= a2y_s.val;
      s3_r2_q    <= s2_r2_q;
      s3_x_q     <= s2_x_q;
      s3_y_q     <= s2_y_q;
      s3_f_q     <= s2_f_q;
      s3_fr_q    <= s2_fr_q;
      s3_ft_q    <= s2_ft_q | a2x_s.ovf | a2y_s.ovf;

      s4_pa_q <= pnu_pkg::smul(coef_i.p2, s3_a2x_q);
      s4_pb_q <= pnu_pkg::smul(coef_i.p1, s3_a2y_q);
      s4_r4_q <= r4_s.val;
      s4_m1_q <= m1_s.val;
      s4_t1_q <= t1_s.val;
      s4_t2_q <= t2_s.val;
      s4_r2_q <= s3_r2_q;
      s4_x_q  <= s3_x_q;
      s4_y_q  <= s3_y_q;
      s4_f_q  <= s3_f_q;
      s4_fr_q <= s3_fr_q | r4_s.ovf | m1_s.ovf;
      s4_ft_q <= s3_ft_q | t1_s.ovf | t2_s.ovf;

      s5_pr6_q <= pnu_pkg::smul(s4_r2_q, s4_r4_q);
      s5_pr8_q <= pnu_pkg::smul(s4_r4_q, s4_r4_q);
      s5_pk2_q <= pnu_pkg::smul(coef_i.k2, s4_r4_q);
      s5_ta_q  <= ta_s.val;
      s5_tb_q  <= tb_s.val;
      s5_t1_q  <= s4_t1_q;
      s5_t2_q  <= s4_t2_q;
      s5_m1_q  <= s4_m1_q;
      s5_x_q   <= s4_x_q;
      s5_y_q   <= s4_y_q;
      s5_f_q   <= s4_f_q;
      s5_fr_q  <= s4_fr_q;
      s5_ft_q  <= s4_ft_q | ta_s.ovf | tb_s.ovf;

      s6_r6_q <= r6_s.val;
      s6_r8_q <= r8_s.val;
      s6_m2_q <= m2_s.val;
      s6_tx_q <= tx_s.val;
      s6_ty_q <= ty_s.val;
      s6_m1_q <= s5_m1_q;
      s6_x_q  <= s5_x_q;
      s6_y_q  <= s5_y_q;
      s6_f_q  <= s5_f_q;
      s6_fr_q <= s5_fr_q | r6_s.ovf | r8_s.ovf | m2_s.ovf;
      s6_ft_q <= s5_ft_q | tx_s.ovf | ty_s.ovf;

      s7_pk3_q <= pnu_pkg::smul(coef_i.k3, s6_r6_q);
      s7_pk4_q <= pnu_pkg::smul(coef_i.k4, s6_r8_q);
      s7_ux_q  <= ux_s.val;
      s7_uy_q  <= uy_s.val;
      s7_m1_q  <= s6_m1_q;
      s7_m2_q  <= s6_m2_q;
      s7_x_q   <= s6_x_q;
      s7_y_q   <= s6_y_q;
      s7_f_q   <= s6_f_q;
      s7_fr_q  <= s6_fr_q;
      s7_ft_q  <= s6_ft_q | ux_s.ovf | uy_s.ovf;

      ux_o  <= tan ? s7_ux_q : s7_x_q;
      uy_o  <= tan ? s7_uy_q : s7_y_q;
      d_o   <= rad ? d_s.val : pnu_pkg::Q24_ONE;
      flt_o <= s7_f_q | (rad & (s7_fr_q | m3_s.ovf | m4_s.ovf | d_s.ovf))
               | (tan & s7_ft_q);
    end
  end

endmodule

@@ design/pixel_to_normalized_undistort.sv @@
// ----------------------------------------------------------------------------
// pixel_to_normalized_undistort
// pixel to normalized camera coordinates with radial/tangential correction
// ----------------------------------------------------------------------------
// Usage: pixel points (signed Q16.16) enter on pix_i, one beat per cycle when
// ready is high; normalized points (signed Q8.24) with a fault flag leave on
// norm_o in the same order, one result per input beat.
// Registers sit on the APB port at byte address 8*index, 64-bit data; write
// them only while no beats are in flight.
// Throughput: one point per cycle, sustained while norm_o accepts results.
// Pipeline: 34 stages of the first divider (prep, 32 quotient bits,
// saturation), 8 stages of the polynomial and 34 stages of the second
// divider, plus the output register.
// Reset: all valid bits clear, registers take their defaults (pinhole, unit
// focal lengths, zero center and coefficients).
// Stall: when norm_o is held off, one more result lands in a skid register;
// only while that register is full does the pipeline freeze and pix_i.ready
// drop, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "pixel_to_normalized_undistort_defines.svh"

module pixel_to_normalized_undistort (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pnu_pix_if.sink                    pix_i,
  pnu_norm_if.source                 norm_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pnu_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  logic [1:0]  mode_q;
  logic [63:0] focal_q, pp_q, k12_q, k34_q, tan_q;
  logic [2:0]  idx;
  logic        wr;

  logic               en;
  logic signed [32:0] n1 [2];
  logic signed [32:0] d1 [2];
  logic signed [31:0] q1 [2];
  logic               v1, f1;

  pnu_pkg::coef_t     coef;
  logic               vp, fp;
  logic signed [31:0] ux, uy, dd;

  logic signed [32:0] n2 [2];
  logic signed [32:0] d2 [2];
  logic signed [31:0] q2 [2];
  logic               v2, f2;

  pnu_pkg::res_t res;
  pnu_pkg::res_t out_q, out_d, skid_q, skid_d;
  logic          out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic          take;

  // configuration port
  assign idx    = paddr[pnu_pkg::ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pnu_pkg::MODE_PINHOLE;
      focal_q <= pnu_pkg::FOCAL_RST;
      pp_q    <= '0;
      k12_q   <= '0;
      k34_q   <= '0;
      tan_q   <= '0;
    end else if (wr) begin
      case (idx)
        pnu_pkg::REG_MODE:  mode_q  <= pwdata[1:0];
        pnu_pkg::REG_FOCAL: focal_q <= pwdata;
        pnu_pkg::REG_PP:    pp_q    <= pwdata;
        pnu_pkg::REG_K12:   k12_q   <= pwdata;
        pnu_pkg::REG_K34:   k34_q   <= pwdata;
        pnu_pkg::REG_TAN:   tan_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pnu_pkg::REG_MODE:  prdata = {62'd0, mode_q};
      pnu_pkg::REG_FOCAL: prdata = focal_q;
      pnu_pkg::REG_PP:    prdata = pp_q;
      pnu_pkg::REG_K12:   prdata = k12_q;
      pnu_pkg::REG_K34:   prdata = k34_q;
      pnu_pkg::REG_TAN:   prdata = tan_q;
      default:            prdata = '0;
    endcase
  end

  // datapath
  assign en          = !skid_valid_q;
  assign pix_i.ready = en;

  assign n1[0] = {pix_i.pixel_x[31], pix_i.pixel_x} - {pp_q[31], pp_q[31:0]};
  assign n1[1] = {pix_i.pixel_y[31], pix_i.pixel_y} - {pp_q[63], pp_q[63:32]};
  assign d1[0] = {1'b0, focal_q[31:0]};
  assign d1[1] = {1'b0, focal_q[63:32]};

  pnu_div u_div_pix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_i.valid),
    .flt_i   (1'b0),
    .num_i   (n1),
    .den_i   (d1),
    .valid_o (v1),
    .flt_o   (f1),
    .quo_o   (q1)
  );

  assign coef.k1 = k12_q[31:0];
  assign coef.k2 = k12_q[63:32];
  assign coef.k3 = k34_q[31:0];
  assign coef.k4 = k34_q[63:32];
  assign coef.p1 = tan_q[31:0];
  assign coef.p2 = tan_q[63:32];

  pnu_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .flt_i   (f1),
    .x_i     (q1[0]),
    .y_i     (q1[1]),
    .mode_i  (mode_q),
    .coef_i  (coef),
    .valid_o (vp),
    .flt_o   (fp),
    .ux_o    (ux),
    .uy_o    (uy),
    .d_o     (dd)
  );

  assign n2[0] = {ux[31], ux};
  assign n2[1] = {uy[31], uy};
  assign d2[0] = {dd[31], dd};
  assign d2[1] = {dd[31], dd};

  pnu_div u_div_rad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vp),
    .flt_i   (fp),
    .num_i   (n2),
    .den_i   (d2),
    .valid_o (v2),
    .flt_o   (f2),
    .quo_o   (q2)
  );

  // output register with skid
  assign res.norm_x = q2[0];
  assign res.norm_y = q2[1];
  assign res.fault  = f2;
  assign take       = out_valid_q && norm_o.ready;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (v2) begin
      if (!out_valid_q || take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign norm_o.valid  = out_valid_q;
  assign norm_o.norm_x = out_q.norm_x;
  assign norm_o.norm_y = out_q.norm_y;
  assign norm_o.fault  = out_q.fault;

  `PNU_ASSERT_NOW(a_skid_needs_out, skid_valid_q, out_valid_q, "skid beat without output beat")
  `PNU_ASSERT_NOW(a_skid_freezes, skid_valid_q, !en, "pipeline moving while skid full")
  `PNU_ASSERT_NEXT(a_stall_to_skid, en && v2 && out_valid_q && !norm_o.ready, skid_valid_q, "result dropped on stall")

endmodule

@@ test/pixel_to_normalized_undistort_tb.sv @@
// ----------------------------------------------------------------------------
// pixel_to_normalized_undistort_tb
// streams pixel points through the block and checks every normalized result
// ----------------------------------------------------------------------------
// Registers are written over the APB port between phases while the pipeline
// is empty. Each phase but the no-idle ones sends points with random gaps
// while the output side stalls at random. A scoreboard predicts every result
// from its own copy of the registers and compares it in order, field by field.
// ----------------------------------------------------------------------------
class norm_scoreboard;
  typedef struct {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic               flt;
  } norm_point_t;

  localparam longint Q1   = 64'sd16777216;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  logic [1:0]  cam_mode;
  logic [63:0] focal, center, k12, k34, tang;
  norm_point_t pending[$];
  int          mismatches;
  bit          flt;

  function new();
    cam_mode = pnu_pkg::MODE_PINHOLE;
    focal = pnu_pkg::FOCAL_RST;
    center = '0;
    k12 = '0;
    k34 = '0;
    tang = '0;
    mismatches = 0;
  endfunction

  function void set_reg(pnu_pkg::reg_idx_e idx, logic [63:0] v);
    case (idx)
      pnu_pkg::REG_MODE: cam_mode = v[1:0];
      pnu_pkg::REG_FOCAL: focal = v;
      pnu_pkg::REG_PP: center = v;
      pnu_pkg::REG_K12: k12 = v;
      pnu_pkg::REG_K34: k34 = v;
      pnu_pkg::REG_TAN: tang = v;
      default: ;
    endcase
  endfunction

  function longint sat(longint v);
    if (v > SMAX) begin
      flt = 1;
      return SMAX;
    end
    if (v < SMIN) begin
      flt = 1;
      return SMIN;
    end
    return v;
  endfunction

  function longint fmul(longint a, longint b);
    return sat((a * b) / Q1);
  endfunction

  function longint fdiv(longint num, longint den);
    if (den == 0) begin
      flt = 1;
      return num > 0 ? SMAX : (num < 0 ? SMIN : 0);
    end
    return sat((num * Q1) / den);
  endfunction

  function longint s32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function void note_pixel(logic signed [31:0] px, logic signed [31:0] py);
    longint x, y, xx, yy, xy, r2, r4, r6, r8, d, ux, uy, tx, ty;
    norm_point_t p;
    flt = 0;
    x = fdiv(longint'(px) - s32(center[31:0]), longint'({32'd0, focal[31:0]}));
    y = fdiv(longint'(py) - s32(center[63:32]), longint'({32'd0, focal[63:32]}));
    if (cam_mode == pnu_pkg::MODE_RADIAL || cam_mode == pnu_pkg::MODE_RADTAN) begin
      xx = fmul(x, x);
      yy = fmul(y, y);
      r2 = sat(xx + yy);
      r4 = fmul(r2, r2);
      r6 = fmul(r2, r4);
      r8 = fmul(r4, r4);
      d = sat(Q1 + fmul(s32(k12[31:0]), r2) + fmul(s32(k12[63:32]), r4)
              + fmul(s32(k34[31:0]), r6) + fmul(s32(k34[63:32]), r8));
      ux = x;
      uy = y;
      if (cam_mode == pnu_pkg::MODE_RADTAN) begin
        xy = fmul(x, y);
        tx = sat(2 * fmul(s32(tang[31:0]), xy)
                 + fmul(s32(tang[63:32]), sat(r2 + 2 * xx)));
        ty = sat(fmul(s32(tang[31:0]), sat(r2 + 2 * yy))
                 + 2 * fmul(s32(tang[63:32]), xy));
        ux = sat(x - tx);
        uy = sat(y - ty);
      end
      x = fdiv(ux, d);
      y = fdiv(uy, d);
    end
    p.nx = x[31:0];
    p.ny = y[31:0];
    p.flt = flt;
    pending.push_back(p);
  endfunction

  function void check_result(logic signed [31:0] nx, logic signed [31:0] ny, logic f);
    norm_point_t p;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected beat: %h %h %b", nx, ny, f);
      return;
    end
    p = pending.pop_front();
    if (p.nx !== nx || p.ny !== ny || p.flt !== f) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %h %h %b, got %h %h %b",
                 p.nx, p.ny, p.flt, nx, ny, f);
    end
  endfunction
endclass

module pixel_to_normalized_undistort_tb;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel, penable, pwrite;
  logic [pnu_pkg::ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;
  bit          no_idle;
  int          out_stall;
  int          idle_cycles;

  pnu_pix_if  pix();
  pnu_norm_if norm();
  norm_scoreboard sb = new();

  pixel_to_normalized_undistort dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .pix_i(pix), .norm_o(norm),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // output side: random backpressure, check each beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      norm.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (norm.valid && norm.ready) sb.check_result(norm.norm_x, norm.norm_y, norm.fault);
      if (out_stall > 0) begin
        out_stall--;
        norm.ready <= 1'b0;
      end else begin
        out_stall = pick_gap();
        norm.ready <= (out_stall == 0);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (norm.valid && norm.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(pnu_pkg::reg_idx_e idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pnu_pkg::ADDR_W'(idx * 8);
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(logic [1:0] m, logic [63:0] f, logic [63:0] c,
                           logic [63:0] ka, logic [63:0] kb, logic [63:0] t);
    write_reg(pnu_pkg::REG_MODE, {62'd0, m});
    write_reg(pnu_pkg::REG_FOCAL, f);
    write_reg(pnu_pkg::REG_PP, c);
    write_reg(pnu_pkg::REG_K12, ka);
    write_reg(pnu_pkg::REG_K34, kb);
    write_reg(pnu_pkg::REG_TAN, t);
  endtask

  task automatic send_pixel(logic signed [31:0] px, logic signed [31:0] py);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel_x <= px;
    pix.pixel_y <= py;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    sb.note_pixel(px, py);
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  function automatic logic [31:0] q16(real v);
    return $rtoi(v * 65536.0);
  endfunction

  function automatic logic [31:0] q24(real v);
    return $rtoi(v * 16777216.0);
  endfunction

  function automatic logic [31:0] small_coef();
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
  endfunction

  task automatic random_points(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) != 0)
        send_pixel($urandom_range(0, 1280 << 16), $urandom_range(0, 960 << 16));
      else
        send_pixel($urandom, $urandom);
    end
  endtask

  task automatic random_phase(int n);
    logic [31:0] fx, fy;
    fx = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(100 << 16, 1500 << 16);
    fy = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(100 << 16, 1500 << 16);
    configure(2'($urandom_range(0, 3)), {fy, fx},
              {$urandom_range(0, 960 << 16), $urandom_range(0, 1280 << 16)},
              {small_coef(), small_coef()}, {small_coef(), small_coef()},
              {small_coef() >>> 4, small_coef() >>> 4});
    no_idle = ($urandom_range(0, 3) == 0);
    random_points(n);
    drain();
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    norm.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_cycles = 0;
    no_idle = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: pinhole, unit focal lengths
    send_pixel(32'sh0000_0000, 32'sh0000_0000);
    send_pixel(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_pixel(32'sh8000_0000, 32'sh8000_0000);
    send_pixel(32'sh7fff_ffff, 32'sh8000_0000);
    send_pixel(32'sh0000_0001, 32'shffff_ffff);
    send_pixel(32'sh0000_0100, 32'shffff_ff00);
    drain();

    // zero focal lengths
    configure(pnu_pkg::MODE_PINHOLE, 64'd0, {q16(-2.0), q16(3.5)}, '0, '0, '0);
    send_pixel(q16(3.5), q16(-2.0));
    send_pixel(q16(5.0), q16(-7.0));
    send_pixel(q16(1.0), q16(9.0));
    drain();

    // radial factor exactly zero at unit radius
    configure(pnu_pkg::MODE_RADIAL, pnu_pkg::FOCAL_RST, '0, {32'd0, q24(-1.0)}, '0, '0);
    send_pixel(q16(1.0), 32'sd0);
    send_pixel(q16(-1.0), 32'sd0);
    send_pixel(32'sd0, q16(1.0));
    send_pixel(q16(0.5), q16(0.25));
    drain();

    // extreme coefficients and focal lengths, both distortion modes
    configure(pnu_pkg::MODE_RADTAN, 64'hffff_ffff_0000_0001, 64'h8000_0000_7fff_ffff,
              64'h7fff_ffff_8000_0000, 64'h8000_0000_7fff_ffff,
              64'h7fff_ffff_8000_0000);
    send_pixel(32'sh7fff_ffff, 32'sh8000_0000);
    send_pixel(32'sh0000_0000, 32'sh0000_0000);
    send_pixel(32'sh8000_0000, 32'sh7fff_ffff);
    drain();
    write_reg(pnu_pkg::REG_MODE, {62'd0, pnu_pkg::MODE_RADIAL});
    send_pixel(32'sh0000_1000, 32'sh0000_2000);
    send_pixel(32'sh7fff_ffff, 32'sh7fff_ffff);
    drain();

    // unused mode code falls back to pinhole
    configure(2'd3, {q16(500.0), q16(500.0)}, {q16(240.0), q16(320.0)},
              {q24(0.1), q24(-0.3)}, '0, '0);
    send_pixel(q16(100.0), q16(400.0));
    send_pixel(q16(640.0), q16(0.0));
    drain();

    // typical lens, full correction
    configure(pnu_pkg::MODE_RADTAN, {q16(600.0), q16(600.0)}, {q16(240.0), q16(320.0)},
              {q24(0.07), q24(-0.28)}, {q24(0.002), q24(-0.01)},
              {q24(-0.0005), q24(0.001)});
    random_points(250);
    drain();

    for (int ph = 0; ph < 9; ph++) random_phase(160);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/pnu_pkg.sv
design/pnu_pix_if.sv
design/pnu_norm_if.sv
design/pnu_div.sv
design/pnu_poly.sv
design/pixel_to_normalized_undistort.sv
test/pixel_to_normalized_undistort_tb.sv
